### src/hism_pkg.sv
// Shared codes for the handle and impact safety monitor.
// Holds event and reason codes and the configuration register indexes.
// No dependencies.
package hism_pkg;

  localparam int unsigned EV_W  = 2;
  localparam int unsigned RS_W  = 2;
  localparam int unsigned IDX_W = 3;
  localparam int unsigned SEC_W = 23;

  // event_res codes
  localparam logic [EV_W-1:0] EV_NONE = 2'd0;
  localparam logic [EV_W-1:0] EV_WARN = 2'd1;
  localparam logic [EV_W-1:0] EV_SHUT = 2'd2;

  // reason codes
  localparam logic [RS_W-1:0] RS_NONE   = 2'd0;
  localparam logic [RS_W-1:0] RS_HANDLE = 2'd1;
  localparam logic [RS_W-1:0] RS_LINK   = 2'd2;
  localparam logic [RS_W-1:0] RS_IMPACT = 2'd3;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_WARNING    = 3'd1;
  localparam logic [IDX_W-1:0] REG_SHUTOFF    = 3'd2;
  localparam logic [IDX_W-1:0] REG_HEALTH_CHK = 3'd3;
  localparam logic [IDX_W-1:0] REG_SAMPLE     = 3'd4;
  localparam logic [IDX_W-1:0] REG_THRESHOLD  = 3'd5;
  localparam logic [IDX_W-1:0] REG_CONFIRM    = 3'd6;

endpackage

### src/hism_ifs.sv
// Channel interfaces of the handle and impact safety monitor: tick input,
// result output and configuration write.
// Depends on hism_pkg for field widths.
interface hism_tick_if;
  logic               valid;
  logic               ready;
  logic [31:0]        now_ms;
  logic               handle_raw;
  logic               power_on;
  logic               link_ok;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;

  modport source (output valid, now_ms, handle_raw, power_on, link_ok,
                  accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, now_ms, handle_raw, power_on, link_ok,
                  accel_x, accel_y, accel_z, output ready);
endinterface

interface hism_res_if;
  logic                          valid;
  logic                          ready;
  logic [hism_pkg::EV_W-1:0]     event_res;
  logic [hism_pkg::RS_W-1:0]     reason;
  logic                          handle_contact;
  logic [hism_pkg::SEC_W-1:0]    seconds_left;
  logic                          sensor_healthy;
  logic                          reinit_request;

  modport source (output valid, event_res, reason, handle_contact, seconds_left,
                  sensor_healthy, reinit_request, input ready);
  modport sink   (input valid, event_res, reason, handle_contact, seconds_left,
                  sensor_healthy, reinit_request, output ready);
endinterface

interface hism_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [hism_pkg::IDX_W-1:0] index;
  logic [31:0]                data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/handle_and_impact_safety_monitor.sv
// Handle and impact safety monitor, top level.
// Depends on hism_pkg and the channel interfaces in hism_ifs.sv.
//
// One tick beat in, one result beat out, in order. The block takes a new beat
// every cycle unless results stall, and each accepted tick passes through the
// registered stages in order: an input stage registers the tick and the three
// axis squares, a state stage runs debounce, link check, impact test and
// inactivity timing and updates all state, and the output stage turns the
// remaining milliseconds into whole seconds with one reciprocal multiply. The
// rate is set by the state stage, where each tick's update must finish before
// the next tick is seen. Configuration writes are taken every cycle and must
// only be made while no tick is in flight. There is no clearing pass after reset.
module handle_and_impact_safety_monitor (
  input  logic            clk,
  input  logic            rst,
  hism_tick_if.sink       tick,
  hism_res_if.source      res,
  hism_cfg_if.sink        cfg
);

  // ceil(rem / 1000) = floor(((rem + 999) >> 3) / 125), done by reciprocal
  localparam int unsigned     DIV_N     = 30;
  localparam int unsigned     DIV_SHIFT = DIV_N + 7;
  localparam logic [30:0]     DIV_RECIP = 31'd1099511628;
  localparam logic [32:0]     MS_ROUND  = 33'd999;

  typedef struct packed {
    logic [hism_pkg::EV_W-1:0] ev;
    logic [hism_pkg::RS_W-1:0] rs;
    logic                      contact;
    logic [31:0]               rem;
    logic                      healthy;
    logic                      reinit;
  } stage_res_t;

  // configuration
  logic [15:0] debounce_ms, health_check_ms, sample_ms, impact_threshold;
  logic [15:0] confirm_ms;
  logic [31:0] warning_ms, shutoff_ms;
  logic [31:0] thr_sq;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms       <= 16'd50;
      warning_ms        <= 32'd25000;
      shutoff_ms        <= 32'd30000;
      health_check_ms   <= 16'd1000;
      sample_ms         <= 16'd10;
      impact_threshold  <= 16'd49152;
      confirm_ms        <= 16'd50;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        hism_pkg::REG_DEBOUNCE:   debounce_ms       <= cfg.data[15:0];
        hism_pkg::REG_WARNING:    warning_ms        <= cfg.data;
        hism_pkg::REG_SHUTOFF:    shutoff_ms        <= cfg.data;
        hism_pkg::REG_HEALTH_CHK: health_check_ms   <= cfg.data[15:0];
        hism_pkg::REG_SAMPLE:     sample_ms         <= cfg.data[15:0];
        hism_pkg::REG_THRESHOLD:  impact_threshold  <= cfg.data[15:0];
        hism_pkg::REG_CONFIRM:    confirm_ms        <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  // threshold squared is registered, following the register in the next cycle
  always_ff @(posedge clk) begin
    thr_sq <= 32'(impact_threshold) * 32'(impact_threshold);
  end

  // pipeline handshake
  logic s1_valid, s2_valid, out_valid;
  logic s1_ready, s2_ready, s3_ready;

  assign s3_ready   = !out_valid || res.ready;
  assign s2_ready   = !s2_valid || s3_ready;
  assign s1_ready   = !s1_valid || s2_ready;
  assign tick.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid  <= tick.valid;
      if (s2_ready) s2_valid  <= s1_valid;
      if (s3_ready) out_valid <= s2_valid;
    end
  end

  // input stage: register the beat and the axis squares
  logic signed [31:0] prod_x, prod_y, prod_z;
  logic [31:0] s1_now;
  logic        s1_raw, s1_power, s1_link;
  logic [30:0] s1_sq_x, s1_sq_y, s1_sq_z;

  assign prod_x = tick.accel_x * tick.accel_x;
  assign prod_y = tick.accel_y * tick.accel_y;
  assign prod_z = tick.accel_z * tick.accel_z;

  always_ff @(posedge clk) begin
    if (tick.valid && s1_ready) begin
      s1_now   <= tick.now_ms;
      s1_raw   <= tick.handle_raw;
      s1_power <= tick.power_on;
      s1_link  <= tick.link_ok;
      s1_sq_x  <= prod_x[30:0];
      s1_sq_y  <= prod_y[30:0];
      s1_sq_z  <= prod_z[30:0];
    end
  end

  // state stage
  logic        raw_last, stable_contact, warning_done, healthy_flag, impact_active;
  logic [31:0] raw_changed_at, released_at, rem_ms;
  logic [31:0] last_check_at, last_sample_at, impact_start_at;

  logic        raw_last_next, stable_contact_next, warning_done_next;
  logic        healthy_flag_next, impact_active_next;
  logic [31:0] raw_changed_at_next, released_at_next, rem_ms_next;
  logic [31:0] last_check_at_next, last_sample_at_next, impact_start_at_next;

  logic [31:0] mag_sum, elapsed;
  logic        over_thr, link_lost, impact_shut;
  stage_res_t  s2_res, s2_res_next;

  always_comb begin
    raw_last_next        = raw_last;
    raw_changed_at_next  = raw_changed_at;
    stable_contact_next  = stable_contact;
    warning_done_next    = warning_done;
    released_at_next     = released_at;
    rem_ms_next          = rem_ms;
    healthy_flag_next    = healthy_flag;
    last_check_at_next   = last_check_at;
    last_sample_at_next  = last_sample_at;
    impact_active_next   = impact_active;
    impact_start_at_next = impact_start_at;
    link_lost            = 1'b0;
    impact_shut          = 1'b0;
    s2_res_next          = '0;

    mag_sum  = 32'(s1_sq_x) + 32'(s1_sq_y) + 32'(s1_sq_z);
    over_thr = mag_sum >= thr_sq;
    elapsed  = '0;

    // debounce
    if (s1_raw != raw_last) begin
      raw_last_next       = s1_raw;
      raw_changed_at_next = s1_now;
    end
    if (s1_raw != stable_contact &&
        (s1_now - raw_changed_at_next) >= 32'(debounce_ms)) begin
      stable_contact_next = s1_raw;
      warning_done_next   = 1'b0;
      rem_ms_next         = '0;
      if (!s1_raw) released_at_next = s1_now;
    end

    // link health check
    if ((s1_now - last_check_at) >= 32'(health_check_ms)) begin
      last_check_at_next = s1_now;
      s2_res_next.reinit = !healthy_flag;
      healthy_flag_next  = s1_link;
      if (healthy_flag && !s1_link) begin
        impact_active_next = 1'b0;
        link_lost          = 1'b1;
      end
    end

    // impact sampling, skipped while the link is down
    if (!link_lost && healthy_flag_next &&
        (s1_now - last_sample_at) >= 32'(sample_ms)) begin
      last_sample_at_next = s1_now;
      if (over_thr) begin
        if (!impact_active) impact_start_at_next = s1_now;
        impact_active_next = 1'b1;
        if ((s1_now - impact_start_at_next) >= 32'(confirm_ms) && s1_power) begin
          impact_active_next = 1'b0;
          impact_shut        = 1'b1;
        end
      end else begin
        impact_active_next = 1'b0;
      end
    end

    if (link_lost) begin
      s2_res_next.ev = hism_pkg::EV_SHUT;
      s2_res_next.rs = hism_pkg::RS_LINK;
    end else if (impact_shut) begin
      s2_res_next.ev = hism_pkg::EV_SHUT;
      s2_res_next.rs = hism_pkg::RS_IMPACT;
    end else if (!s1_power || stable_contact_next) begin
      rem_ms_next = '0;
    end else begin
      // inactivity countdown
      elapsed = s1_now - released_at_next;
      if (elapsed >= shutoff_ms) begin
        rem_ms_next    = '0;
        s2_res_next.ev = hism_pkg::EV_SHUT;
        s2_res_next.rs = hism_pkg::RS_HANDLE;
      end else begin
        rem_ms_next = shutoff_ms - elapsed;
        if (elapsed >= warning_ms && !warning_done_next) begin
          warning_done_next = 1'b1;
          s2_res_next.ev    = hism_pkg::EV_WARN;
        end
      end
    end

    s2_res_next.contact = stable_contact_next;
    s2_res_next.rem     = rem_ms_next;
    s2_res_next.healthy = healthy_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_last        <= 1'b0;
      raw_changed_at  <= '0;
      stable_contact  <= 1'b0;
      warning_done    <= 1'b0;
      released_at     <= '0;
      rem_ms          <= '0;
      healthy_flag    <= 1'b1;
      last_check_at   <= '0;
      last_sample_at  <= '0;
      impact_active   <= 1'b0;
      impact_start_at <= '0;
    end else if (s1_valid && s2_ready) begin
      raw_last        <= raw_last_next;
      raw_changed_at  <= raw_changed_at_next;
      stable_contact  <= stable_contact_next;
      warning_done    <= warning_done_next;
      released_at     <= released_at_next;
      rem_ms          <= rem_ms_next;
      healthy_flag    <= healthy_flag_next;
      last_check_at   <= last_check_at_next;
      last_sample_at  <= last_sample_at_next;
      impact_active   <= impact_active_next;
      impact_start_at <= impact_start_at_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) s2_res <= s2_res_next;
  end

  // output stage: remaining ms to whole seconds, rounded up
  logic [32:0]          rem_round;
  logic [DIV_N-1:0]     div_in;
  logic [DIV_N+30:0]    div_prod;
  logic [hism_pkg::EV_W-1:0]  out_ev;
  logic [hism_pkg::RS_W-1:0]  out_rs;
  logic                       out_contact, out_healthy, out_reinit;
  logic [hism_pkg::SEC_W-1:0] out_seconds;

  assign rem_round = 33'(s2_res.rem) + MS_ROUND;
  assign div_in    = rem_round[32:3];
  assign div_prod  = (DIV_N+31)'(div_in) * (DIV_N+31)'(DIV_RECIP);

  always_ff @(posedge clk) begin
    if (s2_valid && s3_ready) begin
      out_ev      <= s2_res.ev;
      out_rs      <= s2_res.rs;
      out_contact <= s2_res.contact;
      out_healthy <= s2_res.healthy;
      out_reinit  <= s2_res.reinit;
      out_seconds <= div_prod[DIV_SHIFT+hism_pkg::SEC_W-1:DIV_SHIFT];
    end
  end

  assign res.valid          = out_valid;
  assign res.event_res      = out_ev;
  assign res.reason         = out_rs;
  assign res.handle_contact = out_contact;
  assign res.seconds_left   = out_seconds;
  assign res.sensor_healthy = out_healthy;
  assign res.reinit_request = out_reinit;

endmodule

### src/hism_checker.sv
// Port-level checks for the handle and impact safety monitor, bound to the
// top level. Depends on hism_pkg for event and reason codes.
module hism_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic [hism_pkg::EV_W-1:0]  event_res,
  input logic [hism_pkg::RS_W-1:0]  reason,
  input logic                       handle_contact,
  input logic [hism_pkg::SEC_W-1:0] seconds_left,
  input logic                       sensor_healthy
);

  // hold a stalled result beat
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(event_res) && $stable(reason)
      && $stable(seconds_left))
    else $error("result beat changed while stalled");

  a_warn_reason: assert property (@(posedge clk) disable iff (rst)
    res_valid && event_res == hism_pkg::EV_WARN |-> reason == hism_pkg::RS_NONE)
    else $error("warning carries a reason");

  a_shut_reason: assert property (@(posedge clk) disable iff (rst)
    res_valid && (reason != hism_pkg::RS_NONE) |-> event_res == hism_pkg::EV_SHUT)
    else $error("reason without shutdown");

  a_link_unhealthy: assert property (@(posedge clk) disable iff (rst)
    res_valid && reason == hism_pkg::RS_LINK |-> !sensor_healthy)
    else $error("link lost but sensor reported healthy");

  a_countdown_released: assert property (@(posedge clk) disable iff (rst)
    res_valid && seconds_left != '0 |-> !handle_contact)
    else $error("countdown running while handle held");

endmodule

bind handle_and_impact_safety_monitor hism_checker u_hism_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .event_res      (res.event_res),
  .reason         (res.reason),
  .handle_contact (res.handle_contact),
  .seconds_left   (res.seconds_left),
  .sensor_healthy (res.sensor_healthy)
);
